// ===== design/trft_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trft_pkg
// Shared codes and controller/datapath interface types for the region table.
// ----------------------------------------------------------------------------
package trft_pkg;

    localparam int ADDR_W = 32;
    localparam int TID_W  = 18;
    localparam int FID_W  = 16;
    localparam int LEN_W  = 13;

    localparam logic [1:0] OP_MAP_ANON = 2'd0;
    localparam logic [1:0] OP_MAP_FILE = 2'd1;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_TASK_FULL  = 3'd1;
    localparam logic [2:0] ST_OVERLAP    = 3'd2;
    localparam logic [2:0] ST_REGION_FULL = 3'd3;
    localparam logic [2:0] ST_NO_TASK    = 3'd4;
    localparam logic [2:0] ST_NO_REGION  = 3'd5;

    localparam logic [1:0] ACT_MAP  = 2'd0;
    localparam logic [1:0] ACT_LOAD = 2'd1;
    localparam logic [1:0] ACT_ZERO = 2'd2;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_TASK_RD,
        DP_TASK_FOUND,
        DP_ALLOC,
        DP_CNT_RD,
        DP_CNT_LATCH,
        DP_ANON_RD,
        DP_FILE_START,
        DP_FILE_RD,
        DP_HIT_ANON,
        DP_HIT_FILE,
        DP_PAGE,
        DP_APPEND,
        DP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [2:0] code;
    } dp_cmd_t;

    typedef struct packed {
        logic is_fault;
        logic task_end;
        logic task_match;
        logic slot_full;
        logic anon_end;
        logic file_end;
        logic touch;
        logic hit;
        logic region_full;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== design/trft_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trft_ctrl
// Sequencer: task scan and slot allocation, region scans, append, page base, result handoff.
// ----------------------------------------------------------------------------
module trft_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  trft_pkg::dp_stat_t stat,
    output trft_pkg::dp_cmd_t  cmd
);
    import trft_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_T_RD, S_T_CHK, S_T_MISS, S_C_RD, S_C_LAT, S_A_RD, S_A_CHK,
        S_F_START, S_F_RD, S_F_CHK, S_END, S_PAGE, S_RES
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] code_reg, code_next;
    logic       stall_reg, stall_next;

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd.op     = DP_NONE;
        cmd.code   = code_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = S_T_RD;
                end
            end
            S_T_RD:
            begin
                if (stat.task_end)
                    state_next = S_T_MISS;
                else
                begin
                    cmd.op     = DP_TASK_RD;
                    state_next = S_T_CHK;
                end
            end
            S_T_CHK:
            begin
                if (stat.task_match)
                begin
                    cmd.op     = DP_TASK_FOUND;
                    state_next = S_C_RD;
                end
                else
                    state_next = S_T_RD;
            end
            S_T_MISS:
            begin
                if (stat.is_fault)
                begin
                    code_next  = ST_NO_TASK;
                    state_next = S_RES;
                end
                else if (stat.slot_full)
                begin
                    code_next  = ST_TASK_FULL;
                    state_next = S_RES;
                end
                else
                begin
                    cmd.op     = DP_ALLOC;
                    state_next = S_C_RD;
                end
            end
            S_C_RD:
            begin
                cmd.op     = DP_CNT_RD;
                state_next = S_C_LAT;
            end
            S_C_LAT:
            begin
                cmd.op     = DP_CNT_LATCH;
                state_next = S_A_RD;
            end
            S_A_RD:
            begin
                if (stat.anon_end)
                    state_next = S_F_START;
                else
                begin
                    cmd.op     = DP_ANON_RD;
                    state_next = S_A_CHK;
                end
            end
            S_A_CHK:
            begin
                state_next = S_A_RD;
                if (stat.is_fault && stat.hit)
                begin
                    cmd.op     = DP_HIT_ANON;
                    state_next = S_PAGE;
                end
                else if (!stat.is_fault && stat.touch)
                begin
                    code_next  = ST_OVERLAP;
                    state_next = S_RES;
                end
            end
            S_F_START:
            begin
                cmd.op     = DP_FILE_START;
                state_next = S_F_RD;
            end
            S_F_RD:
            begin
                if (stat.file_end)
                    state_next = S_END;
                else
                begin
                    cmd.op     = DP_FILE_RD;
                    state_next = S_F_CHK;
                end
            end
            S_F_CHK:
            begin
                state_next = S_F_RD;
                if (stat.is_fault && stat.hit)
                begin
                    cmd.op     = DP_HIT_FILE;
                    state_next = S_PAGE;
                end
                else if (!stat.is_fault && stat.touch)
                begin
                    code_next  = ST_OVERLAP;
                    state_next = S_RES;
                end
            end
            S_END:
            begin
                state_next = S_RES;
                if (stat.is_fault)
                    code_next = ST_NO_REGION;
                else if (stat.region_full)
                    code_next = ST_REGION_FULL;
                else
                begin
                    cmd.op    = DP_APPEND;
                    code_next = ST_OK;
                end
            end
            S_PAGE:
            begin
                cmd.op     = DP_PAGE;
                code_next  = ST_OK;
                state_next = S_RES;
            end
            S_RES:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = DP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
        stall_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= ST_OK;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
            stall_reg <= stall_next;
        end
    end

    assign in_stall = stall_reg;

endmodule

// ===== design/trft_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trft_dp
// Task and region tables, scan compare, page math and result register.
// ----------------------------------------------------------------------------
module trft_dp #(
    parameter int TASK_SLOTS   = 16,
    parameter int ANON_REGIONS = 16,
    parameter int FILE_REGIONS = 8,
    parameter int PAGE_BYTES   = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  trft_pkg::dp_cmd_t             cmd,
    output trft_pkg::dp_stat_t            stat,
    input  logic [1:0]                    opcode,
    input  logic [trft_pkg::TID_W-1:0]    task_id,
    input  logic [trft_pkg::ADDR_W-1:0]   vaddr,
    input  logic [trft_pkg::ADDR_W-1:0]   region_size,
    input  logic [trft_pkg::ADDR_W-1:0]   backed_size,
    input  logic [trft_pkg::ADDR_W-1:0]   file_offset,
    input  logic [trft_pkg::FID_W-1:0]    file_id,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    status,
    output logic [1:0]                    fault_action,
    output logic [trft_pkg::ADDR_W-1:0]   page_base,
    output logic [trft_pkg::FID_W-1:0]    file_ident_out,
    output logic [trft_pkg::ADDR_W-1:0]   file_position,
    output logic [trft_pkg::LEN_W-1:0]    load_length
);
    import trft_pkg::*;

    localparam int TW     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int TCW    = $clog2(TASK_SLOTS + 1);
    localparam int ACW    = $clog2(ANON_REGIONS + 1);
    localparam int FCW    = $clog2(FILE_REGIONS + 1);
    localparam int RCW    = (ACW > FCW) ? ACW : FCW;
    localparam int ADEPTH = TASK_SLOTS * ANON_REGIONS;
    localparam int FDEPTH = TASK_SLOTS * FILE_REGIONS;
    localparam int AAW    = (ADEPTH > 1) ? $clog2(ADEPTH) : 1;
    localparam int FAW    = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
    localparam int AEW    = 2 * ADDR_W;
    localparam int FEW    = 4 * ADDR_W + FID_W;
    // page size is a power of two: page number times size is the masked offset
    localparam logic [ADDR_W-1:0] PAGE_MASK = ~(ADDR_W'(PAGE_BYTES - 1));

    // latched item
    logic [1:0]        op_reg;
    logic [TID_W-1:0]  id_reg;
    logic [ADDR_W-1:0] addr_reg, size_reg, backed_reg, foff_reg;
    logic [FID_W-1:0]  fid_reg;

    // task table
    logic [TASK_SLOTS-1:0] tvalid_reg;
    logic [TID_W-1:0]      task_mem [TASK_SLOTS];
    logic [TID_W-1:0]      trd_reg;
    logic                  tvrd_reg;
    logic [TW-1:0]         tcand_reg, slot_reg;
    logic [TCW-1:0]        tidx_reg, next_slot_reg;

    // counts
    logic [ACW-1:0] acnt_mem [TASK_SLOTS];
    logic [FCW-1:0] fcnt_mem [TASK_SLOTS];
    logic [ACW-1:0] acrd_reg, acnt_reg;
    logic [FCW-1:0] fcrd_reg, fcnt_reg;
    logic [RCW-1:0] ridx_reg;

    // region stores
    logic [AEW-1:0] anon_mem [ADEPTH];
    logic [FEW-1:0] file_mem [FDEPTH];
    logic [AEW-1:0] ard_reg;
    logic [FEW-1:0] frd_reg;
    logic [AAW-1:0] a_addr, a_wr_addr;
    logic [FAW-1:0] f_addr, f_wr_addr;

    // hit entry and page math
    logic              hfile_reg;
    logic [ADDR_W-1:0] hstart_reg, hsize_reg, hbacked_reg, hoff_reg;
    logic [FID_W-1:0]  hfid_reg;
    logic [ADDR_W-1:0] delta_reg;
    logic [ADDR_W-1:0] prod_reg;

    // result register
    logic              ovalid_reg;
    logic [2:0]        ost_reg;
    logic [1:0]        oact_reg;
    logic [ADDR_W-1:0] obase_reg, opos_reg;
    logic [FID_W-1:0]  ofid_reg;
    logic [LEN_W-1:0]  olen_reg;

    logic [ADDR_W-1:0] cur_start, cur_len, new_end, cur_end;
    logic [ADDR_W-1:0] base, bend, len32, span;
    logic              is_anon_chk;

    assign a_addr    = AAW'(slot_reg) * AAW'(ANON_REGIONS) + AAW'(ridx_reg);
    assign f_addr    = FAW'(slot_reg) * FAW'(FILE_REGIONS) + FAW'(ridx_reg);
    assign a_wr_addr = AAW'(slot_reg) * AAW'(ANON_REGIONS) + AAW'(acnt_reg);
    assign f_wr_addr = FAW'(slot_reg) * FAW'(FILE_REGIONS) + FAW'(fcnt_reg);

    // anon check follows an anon read until the file scan starts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            is_anon_chk <= 1'b1;
        else if (cmd.op == DP_CNT_LATCH)
            is_anon_chk <= 1'b1;
        else if (cmd.op == DP_FILE_START)
            is_anon_chk <= 1'b0;
    end

    always_comb
    begin
        if (is_anon_chk)
        begin
            cur_start = ard_reg[AEW-1 -: ADDR_W];
            cur_len   = ard_reg[ADDR_W-1:0];
        end
        else
        begin
            cur_start = frd_reg[FEW-1 -: ADDR_W];
            cur_len   = frd_reg[FEW-ADDR_W-1 -: ADDR_W];
        end
        cur_end = cur_start + cur_len;
        new_end = addr_reg + size_reg;
    end

    always_comb
    begin
        stat.is_fault    = op_reg[1];
        stat.task_end    = (tidx_reg >= TCW'(TASK_SLOTS));
        stat.task_match  = tvrd_reg && (trd_reg == id_reg);
        stat.slot_full   = (next_slot_reg >= TCW'(TASK_SLOTS));
        stat.anon_end    = (ridx_reg >= RCW'(acnt_reg));
        stat.file_end    = (ridx_reg >= RCW'(fcnt_reg));
        stat.touch       = ((cur_start <= new_end) && (new_end <= cur_end))
                        || ((cur_start <= addr_reg) && (addr_reg <= cur_end))
                        || ((addr_reg <= cur_start) && (cur_end <= new_end));
        stat.hit         = (addr_reg >= cur_start) && (addr_reg <= cur_end);
        stat.region_full = (op_reg == OP_MAP_FILE) ? (fcnt_reg >= FCW'(FILE_REGIONS))
                                                   : (acnt_reg >= ACW'(ANON_REGIONS));
        stat.out_free    = !ovalid_reg || !out_stall;
    end

    // fault result math
    always_comb
    begin
        base = hstart_reg + prod_reg;
        bend = hstart_reg + hbacked_reg;
        span = bend - base;
        if (base + ADDR_W'(PAGE_BYTES) >= bend)
            len32 = span;
        else
            len32 = ADDR_W'(PAGE_BYTES);
        if (len32 > ADDR_W'(PAGE_BYTES))
            len32 = ADDR_W'(PAGE_BYTES);
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_ALLOC)
            task_mem[next_slot_reg[TW-1:0]] <= id_reg;
        if (cmd.op == DP_TASK_RD)
            trd_reg <= task_mem[tidx_reg[TW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_ALLOC)
        begin
            acnt_mem[next_slot_reg[TW-1:0]] <= '0;
            fcnt_mem[next_slot_reg[TW-1:0]] <= '0;
        end
        else if (cmd.op == DP_APPEND)
        begin
            if (op_reg == OP_MAP_FILE)
                fcnt_mem[slot_reg] <= fcnt_reg + 1'b1;
            else
                acnt_mem[slot_reg] <= acnt_reg + 1'b1;
        end
        if (cmd.op == DP_CNT_RD)
        begin
            acrd_reg <= acnt_mem[slot_reg];
            fcrd_reg <= fcnt_mem[slot_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_APPEND && op_reg == OP_MAP_ANON)
            anon_mem[a_wr_addr] <= {addr_reg, size_reg};
        if (cmd.op == DP_ANON_RD)
            ard_reg <= anon_mem[a_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_APPEND && op_reg == OP_MAP_FILE)
            file_mem[f_wr_addr] <= {addr_reg, size_reg, backed_reg, foff_reg, fid_reg};
        if (cmd.op == DP_FILE_RD)
            frd_reg <= file_mem[f_addr];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_LOAD:
            begin
                op_reg     <= opcode;
                id_reg     <= task_id;
                addr_reg   <= vaddr;
                size_reg   <= region_size;
                backed_reg <= backed_size;
                foff_reg   <= file_offset;
                fid_reg    <= file_id;
            end
            DP_TASK_RD:
            begin
                tvrd_reg  <= tvalid_reg[tidx_reg[TW-1:0]];
                tcand_reg <= tidx_reg[TW-1:0];
            end
            DP_TASK_FOUND:
                slot_reg <= tcand_reg;
            DP_ALLOC:
                slot_reg <= next_slot_reg[TW-1:0];
            DP_CNT_LATCH:
            begin
                acnt_reg <= acrd_reg;
                fcnt_reg <= fcrd_reg;
            end
            DP_HIT_ANON:
            begin
                hfile_reg  <= 1'b0;
                hstart_reg <= ard_reg[AEW-1 -: ADDR_W];
                hsize_reg  <= ard_reg[ADDR_W-1:0];
                delta_reg  <= addr_reg - ard_reg[AEW-1 -: ADDR_W];
            end
            DP_HIT_FILE:
            begin
                hfile_reg   <= 1'b1;
                hstart_reg  <= frd_reg[FEW-1 -: ADDR_W];
                hsize_reg   <= frd_reg[FEW-ADDR_W-1 -: ADDR_W];
                hbacked_reg <= frd_reg[FEW-2*ADDR_W-1 -: ADDR_W];
                hoff_reg    <= frd_reg[FID_W+ADDR_W-1 -: ADDR_W];
                hfid_reg    <= frd_reg[FID_W-1:0];
                delta_reg   <= addr_reg - frd_reg[FEW-1 -: ADDR_W];
            end
            DP_PAGE:
                prod_reg <= delta_reg & PAGE_MASK;
            default:
            begin
            end
        endcase
    end

    // control counters and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tvalid_reg    <= '0;
            next_slot_reg <= '0;
            tidx_reg      <= '0;
            ridx_reg      <= '0;
        end
        else
        begin
            case (cmd.op)
                DP_LOAD:       tidx_reg <= '0;
                DP_TASK_RD:    tidx_reg <= tidx_reg + 1'b1;
                DP_ALLOC:
                begin
                    tvalid_reg[next_slot_reg[TW-1:0]] <= 1'b1;
                    next_slot_reg <= next_slot_reg + 1'b1;
                end
                DP_CNT_LATCH:  ridx_reg <= '0;
                DP_FILE_START: ridx_reg <= '0;
                DP_ANON_RD:    ridx_reg <= ridx_reg + 1'b1;
                DP_FILE_RD:    ridx_reg <= ridx_reg + 1'b1;
                default:
                begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (cmd.op == DP_RESULT)
            ovalid_reg <= 1'b1;
        else if (!out_stall)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_RESULT)
        begin
            ost_reg   <= cmd.code;
            oact_reg  <= ACT_MAP;
            obase_reg <= '0;
            ofid_reg  <= '0;
            opos_reg  <= '0;
            olen_reg  <= '0;
            if (cmd.code == ST_OK && op_reg[1])
            begin
                obase_reg <= base;
                if (hfile_reg && addr_reg < bend)
                begin
                    oact_reg <= ACT_LOAD;
                    ofid_reg <= hfid_reg;
                    opos_reg <= hoff_reg + prod_reg;
                    olen_reg <= len32[LEN_W-1:0];
                end
                else if (hfile_reg && addr_reg < hstart_reg + hsize_reg)
                    oact_reg <= ACT_ZERO;
            end
        end
    end

    assign out_valid      = ovalid_reg;
    assign status         = ost_reg;
    assign fault_action   = oact_reg;
    assign page_base      = obase_reg;
    assign file_ident_out = ofid_reg;
    assign file_position  = opos_reg;
    assign load_length    = olen_reg;

endmodule

// ===== design/task_region_table_fault_resolver_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_region_table_fault_resolver_unit
// Per-task anonymous/file region table with map and page-fault resolution.
// ----------------------------------------------------------------------------
// Sequence: each task slot scanned passes S_T_RD then S_T_CHK, each region
//   entry scanned a read and a check state; a fault hit adds S_PAGE for the
//   page base. The result waits in S_RES while the output register is
//   stalled, so any output stall delays out_valid.
// Throughput: one transaction in flight; in_stall is high from acceptance
//   until the result is loaded into the output register.
// Reset: async, active low; clears task valid bits, slot pointer and control.
//   Region stores and counts need no clearing (counts are written on alloc).
// PAGE_BYTES must be a power of two.
// ----------------------------------------------------------------------------
module task_region_table_fault_resolver_unit #(
    parameter int TASK_SLOTS   = 16,
    parameter int ANON_REGIONS = 16,
    parameter int FILE_REGIONS = 8,
    parameter int PAGE_BYTES   = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   opcode,
    input  logic [trft_pkg::TID_W-1:0]   task_id,
    input  logic [trft_pkg::ADDR_W-1:0]  vaddr,
    input  logic [trft_pkg::ADDR_W-1:0]  region_size,
    input  logic [trft_pkg::ADDR_W-1:0]  backed_size,
    input  logic [trft_pkg::ADDR_W-1:0]  file_offset,
    input  logic [trft_pkg::FID_W-1:0]   file_id,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [2:0]                   status,
    output logic [1:0]                   fault_action,
    output logic [trft_pkg::ADDR_W-1:0]  page_base,
    output logic [trft_pkg::FID_W-1:0]   file_ident_out,
    output logic [trft_pkg::ADDR_W-1:0]  file_position,
    output logic [trft_pkg::LEN_W-1:0]   load_length
);
    import trft_pkg::*;

    // Controller sequences the scans; datapath owns every table, the payload and result registers.
    dp_cmd_t  cmd;
    dp_stat_t stat;

    trft_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Inputs are captured on the accept cycle (DP_LOAD), so the upstream
    // payload is only sampled while in_stall is low.
    trft_dp #(
        .TASK_SLOTS   (TASK_SLOTS),
        .ANON_REGIONS (ANON_REGIONS),
        .FILE_REGIONS (FILE_REGIONS),
        .PAGE_BYTES   (PAGE_BYTES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .opcode         (opcode),
        .task_id        (task_id),
        .vaddr          (vaddr),
        .region_size    (region_size),
        .backed_size    (backed_size),
        .file_offset    (file_offset),
        .file_id        (file_id),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .fault_action   (fault_action),
        .page_base      (page_base),
        .file_ident_out (file_ident_out),
        .file_position  (file_position),
        .load_length    (load_length)
    );

endmodule

// ===== design/trft_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trft_checker
// Port-level checks for the region table, bound to the top level.
// ----------------------------------------------------------------------------
module trft_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [2:0]                   status,
    input logic [1:0]                   fault_action,
    input logic [trft_pkg::ADDR_W-1:0]  page_base,
    input logic [trft_pkg::ADDR_W-1:0]  file_position,
    input logic [trft_pkg::LEN_W-1:0]   load_length
);
    import trft_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second transaction taken while busy");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> fault_action == ACT_MAP && page_base == '0)
        else $error("failed transaction carries fault data");

    a_noload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fault_action != ACT_LOAD |-> file_position == '0 && load_length == '0)
        else $error("load fields set without load action");

endmodule

bind task_region_table_fault_resolver_unit trft_checker u_trft_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .fault_action  (fault_action),
    .page_base     (page_base),
    .file_position (file_position),
    .load_length   (load_length)
);
